### rtl/core/fns_pkg.sv
package fns_pkg;

  localparam int FREQ_W = 23;
  localparam int SEMI_W = 8;
  localparam int MID_W  = FREQ_W + 1;

  typedef logic [FREQ_W-1:0]        freq_t;
  typedef logic signed [SEMI_W-1:0] semitone_t;
  typedef logic [MID_W-1:0]         mid_t;

  localparam freq_t FREQ_MAX = {FREQ_W{1'b1}};
  // Marks a boundary past the table: no input reaches it.
  localparam mid_t  MID_NONE = {1'b1, {FREQ_W{1'b0}}};

  localparam logic [63:0] FIVE_POW_13 = 64'd1220703125;

  // 2^(k/12) times 10^13, rounded
  localparam logic [63:0] RATIO_DEC [12] = '{
    64'd10000000000000, 64'd10594630943593, 64'd11224620483094,
    64'd11892071150027, 64'd12599210498949, 64'd13348398541700,
    64'd14142135623731, 64'd14983070768767, 64'd15874010519682,
    64'd16817928305074, 64'd17817974362807, 64'd18877486253634
  };

  // Semitone ratio 2^(k/12) in Q31, k = 0..12
  function automatic logic [63:0] ratio_q31(input int k);
    logic [63:0] r;
    if (k >= 12) begin
      r = 64'h1 << 32;
    end else begin
      r = (RATIO_DEC[k] * (64'h1 << 18) + FIVE_POW_13 / 64'd2) / FIVE_POW_13;
    end
    return r;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'h1 << 62;
    rem  = v;
    for (int n = 0; n < 32; n++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 440 Hz scaled by a Q31 ratio and 2^oct, rounded half up, saturated
  function automatic freq_t scale_freq(input logic [63:0] ratio, input int oct,
                                       input int fb);
    logic [63:0] v;
    int          sh;
    v  = (64'd440 << fb) * ratio;
    sh = 31 - oct;
    v  = (v + (64'h1 << (sh - 1))) >> sh;
    return (v > 64'(FREQ_MAX)) ? FREQ_MAX : v[FREQ_W-1:0];
  endfunction

  function automatic freq_t pitch_entry(input int i, input int below, input int fb);
    int m;
    m = i - below - 9 + 240;
    return scale_freq(ratio_q31(m % 12), m / 12 - 20, fb);
  endfunction

  function automatic mid_t mid_entry(input int i, input int depth, input int below,
                                     input int fb);
    int   m;
    mid_t r;
    m = i - below - 9 + 240;
    if (i >= depth - 1) begin
      r = MID_NONE;
    end else begin
      r = {1'b0, scale_freq(isqrt64(ratio_q31(m % 12) * ratio_q31(m % 12 + 1)),
                            m / 12 - 20, fb)};
    end
    return r;
  endfunction

  function automatic freq_t abs_diff(input freq_t a, input freq_t b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

### rtl/core/fns_search_stage.sv
module fns_search_stage #(
  parameter int LOWEST_SEMITONE  = -48,
  parameter int HIGHEST_SEMITONE = 83,
  parameter int FRACTION_BITS    = 8,
  parameter int STEP_BIT         = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  fns_pkg::freq_t      up_freq,
  input  logic [$clog2(HIGHEST_SEMITONE-LOWEST_SEMITONE+1)-1:0] up_idx,
  output logic                dn_valid,
  input  logic                dn_ready,
  output fns_pkg::freq_t      dn_freq,
  output logic [$clog2(HIGHEST_SEMITONE-LOWEST_SEMITONE+1)-1:0] dn_idx
);
  import fns_pkg::*;

  localparam int DEPTH = HIGHEST_SEMITONE - LOWEST_SEMITONE + 1;
  localparam int BELOW = -LOWEST_SEMITONE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int ROM_N = 1 << IDX_W;
  localparam logic [IDX_W-1:0] STEP_MASK = IDX_W'(1) << STEP_BIT;

  mid_t             mid_rom [ROM_N];
  logic [IDX_W-1:0] cand;
  logic [IDX_W-1:0] probe;
  logic             take;
  logic             valid_r;
  freq_t            freq_r;
  logic [IDX_W-1:0] idx_r;

  for (genvar g = 0; g < ROM_N; g++) begin : g_rom
    assign mid_rom[g] = mid_entry(g, DEPTH, BELOW, FRACTION_BITS);
  end

  // Try setting this bit: keep it when the input sits at or above the boundary below it.
  assign cand  = up_idx | STEP_MASK;
  assign probe = cand - IDX_W'(1);
  assign take  = {1'b0, up_freq} >= mid_rom[probe];

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      freq_r <= up_freq;
      idx_r  <= take ? cand : up_idx;
    end
  end

  assign dn_valid = valid_r;
  assign dn_freq  = freq_r;
  assign dn_idx   = idx_r;

endmodule

### rtl/core/frequency_to_nearest_semitone_core.sv
// Nearest equal-tempered semitone for a measured pitch (A4 = 440 Hz, 0 = C4).
// Input channel: in_valid/in_ready with in_freq_q8, a frequency in Hz with
// FRACTION_BITS fraction bits. Result channel: out_valid/out_ready with
// out_semitone (signed), out_nearest_freq_q8 (reference frequency of that
// semitone) and out_out_of_range (input below the lowest or above the highest
// table frequency; the lowest or highest semitone is then reported).
// Work: a binary search over the geometric midpoint table, one index bit per
// pipeline stage, then a stage that measures the linear distance to the
// neighbors x-1, x, x+1, then the output register that holds the pick.
// A new transaction is taken on every clock while the receiver does not stall;
// the sustained rate is then one item per cycle, set by the one-bit-per-stage
// search pipeline.
// Reset clears every stage valid bit and the output valid; the tables are
// constants, so the block takes transactions right after reset.
// When the receiver stalls, each stage holds its item until the stage after it
// frees up; in_ready drops only once every stage is full, and nothing is lost
// or repeated.
module frequency_to_nearest_semitone_core #(
  parameter int LOWEST_SEMITONE  = -48,
  parameter int HIGHEST_SEMITONE = 83,
  parameter int FRACTION_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fns_pkg::freq_t        in_freq_q8,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fns_pkg::semitone_t    out_semitone,
  output fns_pkg::freq_t        out_nearest_freq_q8,
  output logic                  out_out_of_range
);
  import fns_pkg::*;

  localparam int DEPTH = HIGHEST_SEMITONE - LOWEST_SEMITONE + 1;
  localparam int BELOW = -LOWEST_SEMITONE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int ROM_N = 1 << IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Reference frequencies, padded to a power of two.
  freq_t pitch_rom [ROM_N];

  for (genvar g = 0; g < ROM_N; g++) begin : g_rom
    if (g < DEPTH) begin : g_used
      assign pitch_rom[g] = pitch_entry(g, BELOW, FRACTION_BITS);
    end else begin : g_pad
      assign pitch_rom[g] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Search pipeline: stage g decides index bit IDX_W-1-g.
  // ---------------------------------------------------------------------------
  logic             s_valid [IDX_W+1];
  logic             s_ready [IDX_W+1];
  freq_t            s_freq  [IDX_W+1];
  logic [IDX_W-1:0] s_idx   [IDX_W+1];

  assign s_valid[0] = in_valid;
  assign s_freq[0]  = in_freq_q8;
  assign s_idx[0]   = '0;
  assign in_ready   = s_ready[0];

  for (genvar g = 0; g < IDX_W; g++) begin : g_search
    fns_search_stage #(
      .LOWEST_SEMITONE  (LOWEST_SEMITONE),
      .HIGHEST_SEMITONE (HIGHEST_SEMITONE),
      .FRACTION_BITS    (FRACTION_BITS),
      .STEP_BIT         (IDX_W - 1 - g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (s_valid[g]),
      .up_ready (s_ready[g]),
      .up_freq  (s_freq[g]),
      .up_idx   (s_idx[g]),
      .dn_valid (s_valid[g+1]),
      .dn_ready (s_ready[g+1]),
      .dn_freq  (s_freq[g+1]),
      .dn_idx   (s_idx[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Distance stage: read x-1, x, x+1 and take linear distances.
  // ---------------------------------------------------------------------------
  logic             a_valid_r;
  logic             a_ready;
  logic [IDX_W-1:0] a_x_r;
  logic             a_has0_r;
  logic             a_has2_r;
  logic             a_oor_r;
  freq_t            a_d0_r, a_d1_r, a_d2_r;
  freq_t            a_p0_r, a_p1_r, a_p2_r;

  logic             sx_has0, sx_has2;
  freq_t            sx_f;
  logic [IDX_W-1:0] sx_x;
  freq_t            sx_p0, sx_p1, sx_p2;

  always_comb begin
    sx_x    = s_idx[IDX_W];
    sx_f    = s_freq[IDX_W];
    sx_has0 = (sx_x != '0);
    sx_has2 = (sx_x != LAST_IDX);
    sx_p1   = pitch_rom[sx_x];
    sx_p0   = sx_has0 ? pitch_rom[sx_x - IDX_W'(1)] : '0;
    sx_p2   = sx_has2 ? pitch_rom[sx_x + IDX_W'(1)] : '0;
  end

  logic b_ready;

  assign a_ready          = !a_valid_r || b_ready;
  assign s_ready[IDX_W]   = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= s_valid[IDX_W];
    end
    if (a_ready && s_valid[IDX_W]) begin
      a_x_r    <= sx_x;
      a_has0_r <= sx_has0;
      a_has2_r <= sx_has2;
      a_oor_r  <= (sx_f < pitch_rom[0]) || (sx_f > pitch_rom[DEPTH-1]);
      a_d0_r   <= sx_has0 ? abs_diff(sx_p0, sx_f) : '0;
      a_d1_r   <= abs_diff(sx_p1, sx_f);
      a_d2_r   <= sx_has2 ? abs_diff(sx_p2, sx_f) : '0;
      a_p0_r   <= sx_p0;
      a_p1_r   <= sx_p1;
      a_p2_r   <= sx_p2;
    end
  end

  // ---------------------------------------------------------------------------
  // Pick and output register. Keep x unless a neighbor is strictly nearest.
  // ---------------------------------------------------------------------------
  logic             out_valid_r;
  semitone_t        semitone_r;
  freq_t            nearest_r;
  logic             oor_r;
  logic [IDX_W-1:0] pick;
  freq_t            pick_freq;

  always_comb begin
    priority if (a_has0_r && (a_d0_r < a_d1_r) && (!a_has2_r || (a_d0_r < a_d2_r))) begin
      pick      = a_x_r - IDX_W'(1);
      pick_freq = a_p0_r;
    end else if (a_has2_r && (a_d2_r < a_d1_r) && (!a_has0_r || (a_d2_r < a_d0_r))) begin
      pick      = a_x_r + IDX_W'(1);
      pick_freq = a_p2_r;
    end else begin
      pick      = a_x_r;
      pick_freq = a_p1_r;
    end
  end

  assign b_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_ready) begin
      out_valid_r <= a_valid_r;
    end
    if (b_ready && a_valid_r) begin
      semitone_r <= semitone_t'(SEMI_W'(pick) + SEMI_W'(LOWEST_SEMITONE));
      nearest_r  <= pick_freq;
      oor_r      <= a_oor_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_semitone        = semitone_r;
  assign out_nearest_freq_q8 = nearest_r;
  assign out_out_of_range    = oor_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !a_valid_r)
    else $error("reset left a stage valid");

  a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> a_x_r <= LAST_IDX)
    else $error("search index beyond table");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_ready |=> a_valid_r && $stable(a_x_r) && $stable(a_d1_r))
    else $error("distance stage dropped a stalled item");

  a_oor_at_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && oor_r |->
      (semitone_r == semitone_t'(SEMI_W'(LOWEST_SEMITONE))) ||
      (semitone_r == semitone_t'(SEMI_W'(HIGHEST_SEMITONE))))
    else $error("out of range input not mapped to a table end");

endmodule
